@@ rtl/rsd_pkg.sv @@
// Shared types and constants for the run-length sprite decoder.
// No dependencies; every other file of the block imports this package.
package rsd_pkg;

	// Input operation codes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_PIXEL   = 2'd0;
	localparam logic [1:0] ST_FINISH  = 2'd1;
	localparam logic [1:0] ST_BAD_HDR = 2'd2;
	localparam logic [1:0] ST_REFUSED = 2'd3;

	// Decoder phases
	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_BODY   = 3'd1;
	localparam logic [2:0] PH_LEN_HI = 3'd2;
	localparam logic [2:0] PH_LEN_LO = 3'd3;
	localparam logic [2:0] PH_RUN    = 3'd4;

	// Header byte positions
	localparam logic [3:0] HB_MAGIC_R = 4'd0;
	localparam logic [3:0] HB_MAGIC_L = 4'd1;
	localparam logic [3:0] HB_MAGIC_E = 4'd2;
	localparam logic [3:0] HB_LEN_SEL = 4'd3;
	localparam logic [3:0] HB_SIZE_0  = 4'd4;
	localparam logic [3:0] HB_SIZE_1  = 4'd5;
	localparam logic [3:0] HB_SIZE_2  = 4'd6;
	localparam logic [3:0] HB_SIZE_3  = 4'd7;
	localparam logic [3:0] HB_WIDTH_0 = 4'd8;
	localparam logic [3:0] HB_WIDTH_1 = 4'd9;
	localparam logic [3:0] HB_HGT_0   = 4'd10;
	localparam logic [3:0] HB_LAST    = 4'd11;

	localparam logic [7:0] MAGIC_R   = 8'h52;
	localparam logic [7:0] MAGIC_L   = 8'h4C;
	localparam logic [7:0] MAGIC_E   = 8'h45;
	localparam logic [7:0] LEN_NARROW = 8'd8;
	localparam logic [7:0] LEN_WIDE   = 8'd16;

	// Configuration register indexes
	localparam logic [1:0] REG_ORIGIN_X    = 2'd0;
	localparam logic [1:0] REG_ORIGIN_Y    = 2'd1;
	localparam logic [1:0] REG_ORIENTATION = 2'd2;
	localparam logic [1:0] REG_TRANSP_KEY  = 2'd3;

	// Orientation bits
	localparam int ORI_MIRROR_H = 0;
	localparam int ORI_MIRROR_V = 1;

	localparam logic [8:0] KEY_RESET = 9'd256;

	// One result before the origin is applied
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] dx;
		logic [15:0] dy;
		logic [7:0]  color;
	} rsd_res_t;

	// Everything one accepted item produces: one to three results
	typedef struct packed {
		logic [1:0]          cnt;
		rsd_res_t [2:0]      res;
	} rsd_entry_t;

	localparam rsd_res_t RES_FINISH  = '{status: ST_FINISH,  dx: '0, dy: '0, color: '0};
	localparam rsd_res_t RES_BAD_HDR = '{status: ST_BAD_HDR, dx: '0, dy: '0, color: '0};
	localparam rsd_res_t RES_REFUSED = '{status: ST_REFUSED, dx: '0, dy: '0, color: '0};

endpackage

@@ rtl/rle_sprite_decoder.sv @@
// Run-length sprite decoder, top level. Depends on rsd_pkg, rsd_front,
// rsd_queue and rsd_back.
//
// The block takes a sprite one beat at a time: either a stream byte (a
// 12-byte header with magic, run-length width, body size, width and height,
// then the coded body) or a tick that draws one pixel of a pending run.
// Each accepted beat is decoded in the cycle it is accepted and gives zero
// to three results (pixels, image finished, bad header, refused byte); these
// go into a four-entry queue and leave through a registered output one per
// cycle while out_ready is high. A beat can be accepted every cycle while
// the queue has room, so a stream whose beats each give at most one result
// runs at one beat per cycle unless the output stalls; otherwise the output
// port's one-result-per-cycle rate is what limits throughput. Pixels are
// placed at the origin plus column and row, mirrored as the orientation
// register says; transparent pixels still advance the position.
// Configuration writes must only be made while the block is idle.
module rle_sprite_decoder
	import rsd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [7:0]         stream_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [15:0] pixel_x,
	output logic signed [15:0] pixel_y,
	output logic [7:0]         pixel_color,
	output logic               last
);

	logic signed [15:0] origin_x_q, origin_y_q;
	logic [1:0]         orientation_q;
	logic [8:0]         transp_key_q;

	logic       accept;
	logic       q_push, q_pop, q_full, q_empty;
	rsd_entry_t q_in, q_head;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			orientation_q <= '0;
			transp_key_q  <= KEY_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ORIGIN_X:    origin_x_q    <= cfg_wdata;
				REG_ORIGIN_Y:    origin_y_q    <= cfg_wdata;
				REG_ORIENTATION: orientation_q <= cfg_wdata[1:0];
				REG_TRANSP_KEY:  transp_key_q  <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	// The queue has room for everything one beat can produce, so the input
	// side only waits when the output side has fallen behind.
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	rsd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.opcode          (opcode),
		.stream_byte     (stream_byte),
		.orientation     (orientation_q),
		.transparent_key (transp_key_q),
		.push            (q_push),
		.entry           (q_in)
	);

	rsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	rsd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.empty       (q_empty),
		.origin_x    (origin_x_q),
		.origin_y    (origin_y_q),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last        (last)
	);

`ifndef SYNTHESIS
	// The back end must never take an entry the queue does not hold.
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue popped while empty");

	// The front end must never push into a full queue.
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue pushed while full");

	// Status results other than pixels carry no position or colour.
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_PIXEL) |->
			(pixel_x == 16'sd0 && pixel_y == 16'sd0 && pixel_color == 8'd0))
		else $error("non-pixel result with non-zero fields");
`endif

endmodule

@@ rtl/rsd_front.sv @@
// Front end of the sprite decoder: header parsing, run-length decoding and
// pixel placement. Depends on rsd_pkg; pushes at most one entry per item.
module rsd_front
	import rsd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             opcode,
	input  logic [7:0]       stream_byte,
	input  logic [1:0]       orientation,
	input  logic [8:0]       transparent_key,
	output logic             push,
	output rsd_entry_t       entry
);

	typedef struct packed {
		logic        drawn;
		rsd_res_t    res;
		logic [15:0] col;
		logic [15:0] row;
	} rsd_pix_t;

	// Places one pixel and advances the position, drawn or not.
	function automatic rsd_pix_t pix_step(input logic [15:0] col, input logic [15:0] row,
			input logic [15:0] wid, input logic [15:0] hgt, input logic [1:0] orient,
			input logic [8:0] key, input logic [7:0] c);
		rsd_pix_t    p;
		logic [15:0] col_inc;
		p.drawn     = ({1'b0, c} != key);
		p.res.status = ST_PIXEL;
		p.res.dx    = orient[ORI_MIRROR_H] ? (wid - 16'd1 - col) : col;
		p.res.dy    = orient[ORI_MIRROR_V] ? (hgt - 16'd1 - row) : row;
		p.res.color = c;
		col_inc     = col + 16'd1;
		if (col_inc == wid) begin
			p.col = '0;
			p.row = row + 16'd1;
		end else begin
			p.col = col_inc;
			p.row = row;
		end
		return p;
	endfunction

	logic [2:0]  phase_q, nxt_phase;
	logic [3:0]  hdr_idx_q, nxt_hdr_idx;
	logic        wide_q, nxt_wide;
	logic [31:0] body_size_q, nxt_body_size;
	logic [31:0] consumed_q, nxt_consumed;
	logic [15:0] width_q, nxt_width;
	logic [15:0] height_q, nxt_height;
	logic [7:0]  held_byte_q, nxt_held_byte;
	logic        held_valid_q, nxt_held_valid;
	logic [7:0]  run_color_q, nxt_run_color;
	logic [15:0] run_rem_q, nxt_run_rem;
	logic [15:0] col_q, nxt_col;
	logic [15:0] row_q, nxt_row;

	logic [31:0] cons_inc;
	logic        end_after_byte, end_now;
	rsd_pix_t    p_run, p_held, p_lit1, p_lit2;
	rsd_res_t    res_v [3];
	logic [1:0]  n_v;
	logic        fin, bad;

	assign cons_inc       = consumed_q + 32'd1;
	assign end_after_byte = (cons_inc >= body_size_q);
	assign end_now        = (consumed_q >= body_size_q);

	assign p_run  = pix_step(col_q, row_q, width_q, height_q, orientation, transparent_key,
		run_color_q);
	assign p_held = pix_step(col_q, row_q, width_q, height_q, orientation, transparent_key,
		held_byte_q);
	assign p_lit1 = pix_step(col_q, row_q, width_q, height_q, orientation, transparent_key,
		stream_byte);
	assign p_lit2 = pix_step(p_held.col, p_held.row, width_q, height_q, orientation,
		transparent_key, stream_byte);

	always_comb begin
		nxt_phase      = phase_q;
		nxt_hdr_idx    = hdr_idx_q;
		nxt_wide       = wide_q;
		nxt_body_size  = body_size_q;
		nxt_consumed   = consumed_q;
		nxt_width      = width_q;
		nxt_height     = height_q;
		nxt_held_byte  = held_byte_q;
		nxt_held_valid = held_valid_q;
		nxt_run_color  = run_color_q;
		nxt_run_rem    = run_rem_q;
		nxt_col        = col_q;
		nxt_row        = row_q;
		for (int i = 0; i < 3; i++) res_v[i] = '0;
		n_v = '0;
		fin = 1'b0;
		bad = 1'b0;

		if (accept) begin
			if (opcode == OP_TICK) begin
				// A tick outside a run does nothing.
				if (phase_q == PH_RUN) begin
					if (p_run.drawn) begin
						res_v[n_v] = p_run.res;
						n_v = n_v + 2'd1;
					end
					nxt_col     = p_run.col;
					nxt_row     = p_run.row;
					nxt_run_rem = run_rem_q - 16'd1;
					if (nxt_run_rem == 16'd0) begin
						if (end_now) fin = 1'b1;
						else nxt_phase = PH_BODY;
					end
				end
			end else if (phase_q == PH_RUN) begin
				res_v[n_v] = RES_REFUSED;
				n_v = n_v + 2'd1;
			end else if (phase_q == PH_HEADER) begin
				case (hdr_idx_q)
					HB_MAGIC_R: bad = (stream_byte != MAGIC_R);
					HB_MAGIC_L: bad = (stream_byte != MAGIC_L);
					HB_MAGIC_E: bad = (stream_byte != MAGIC_E);
					HB_LEN_SEL: begin
						if (stream_byte == LEN_NARROW) nxt_wide = 1'b0;
						else if (stream_byte == LEN_WIDE) nxt_wide = 1'b1;
						else bad = 1'b1;
					end
					HB_SIZE_0: nxt_body_size = {24'd0, stream_byte};
					HB_SIZE_1, HB_SIZE_2, HB_SIZE_3:
						nxt_body_size = {body_size_q[23:0], stream_byte};
					HB_WIDTH_0: nxt_width = {8'd0, stream_byte};
					HB_WIDTH_1: nxt_width = {width_q[7:0], stream_byte};
					HB_HGT_0: nxt_height = {8'd0, stream_byte};
					default: nxt_height = {height_q[7:0], stream_byte};
				endcase
				if (bad) begin
					nxt_hdr_idx = HB_MAGIC_R;
					res_v[n_v] = RES_BAD_HDR;
					n_v = n_v + 2'd1;
				end else if (hdr_idx_q < HB_LAST) begin
					nxt_hdr_idx = hdr_idx_q + 4'd1;
				end else begin
					nxt_hdr_idx    = HB_MAGIC_R;
					nxt_consumed   = '0;
					nxt_col        = '0;
					nxt_row        = '0;
					nxt_held_valid = 1'b0;
					nxt_run_rem    = '0;
					nxt_phase      = PH_BODY;
					if (nxt_body_size == 32'd0) fin = 1'b1;
				end
			end else begin
				nxt_consumed = cons_inc;
				case (phase_q)
					PH_LEN_HI: begin
						nxt_run_rem = {stream_byte, 8'd0};
						if (end_after_byte) fin = 1'b1;
						else nxt_phase = PH_LEN_LO;
					end
					PH_LEN_LO: begin
						nxt_run_rem = run_rem_q | {8'd0, stream_byte};
						if (nxt_run_rem != 16'd0) nxt_phase = PH_RUN;
						else if (end_after_byte) fin = 1'b1;
						else nxt_phase = PH_BODY;
					end
					default: begin
						if (!held_valid_q) begin
							nxt_held_byte  = stream_byte;
							nxt_held_valid = 1'b1;
							if (end_after_byte) begin
								if (p_lit1.drawn) begin
									res_v[n_v] = p_lit1.res;
									n_v = n_v + 2'd1;
								end
								nxt_col = p_lit1.col;
								nxt_row = p_lit1.row;
								fin = 1'b1;
							end
						end else if (held_byte_q != stream_byte) begin
							if (p_held.drawn) begin
								res_v[n_v] = p_held.res;
								n_v = n_v + 2'd1;
							end
							nxt_col       = p_held.col;
							nxt_row       = p_held.row;
							nxt_held_byte = stream_byte;
							if (end_after_byte) begin
								if (p_lit2.drawn) begin
									res_v[n_v] = p_lit2.res;
									n_v = n_v + 2'd1;
								end
								nxt_col = p_lit2.col;
								nxt_row = p_lit2.row;
								fin = 1'b1;
							end
						end else begin
							nxt_run_color  = held_byte_q;
							nxt_held_valid = 1'b0;
							nxt_run_rem    = '0;
							if (end_after_byte) fin = 1'b1;
							else nxt_phase = wide_q ? PH_LEN_HI : PH_LEN_LO;
						end
					end
				endcase
			end

			// Finishing always comes last and returns to header parsing.
			if (fin) begin
				nxt_phase      = PH_HEADER;
				nxt_hdr_idx    = HB_MAGIC_R;
				nxt_held_valid = 1'b0;
				nxt_run_rem    = '0;
				res_v[n_v] = RES_FINISH;
				n_v = n_v + 2'd1;
			end
		end
	end

	assign push      = accept && (n_v != 2'd0);
	assign entry.cnt = n_v;
	assign entry.res[0] = res_v[0];
	assign entry.res[1] = res_v[1];
	assign entry.res[2] = res_v[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			hdr_idx_q    <= HB_MAGIC_R;
			wide_q       <= 1'b0;
			body_size_q  <= '0;
			consumed_q   <= '0;
			width_q      <= '0;
			height_q     <= '0;
			held_byte_q  <= '0;
			held_valid_q <= 1'b0;
			run_color_q  <= '0;
			run_rem_q    <= '0;
			col_q        <= '0;
			row_q        <= '0;
		end else begin
			phase_q      <= nxt_phase;
			hdr_idx_q    <= nxt_hdr_idx;
			wide_q       <= nxt_wide;
			body_size_q  <= nxt_body_size;
			consumed_q   <= nxt_consumed;
			width_q      <= nxt_width;
			height_q     <= nxt_height;
			held_byte_q  <= nxt_held_byte;
			held_valid_q <= nxt_held_valid;
			run_color_q  <= nxt_run_color;
			run_rem_q    <= nxt_run_rem;
			col_q        <= nxt_col;
			row_q        <= nxt_row;
		end
	end

endmodule

@@ rtl/rsd_queue.sv @@
// Short first-in first-out queue of decoded entries between front and back.
// Depends on rsd_pkg for the entry type.
module rsd_queue
	import rsd_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  rsd_entry_t push_data,
	input  logic       pop,
	output rsd_entry_t head,
	output logic       full,
	output logic       empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rsd_entry_t    slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

endmodule

@@ rtl/rsd_back.sv @@
// Back end of the sprite decoder: walks the results of each queue entry,
// adds the screen origin to pixel results and holds one result in the
// output register. Depends on rsd_pkg.
module rsd_back
	import rsd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  rsd_entry_t         head,
	input  logic               empty,
	input  logic signed [15:0] origin_x,
	input  logic signed [15:0] origin_y,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [15:0] pixel_x,
	output logic signed [15:0] pixel_y,
	output logic [7:0]         pixel_color,
	output logic               last
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic       load, is_last;
	rsd_res_t   cur;

	always_comb begin
		case (idx_q)
			2'd0: cur = head.res[0];
			2'd1: cur = head.res[1];
			default: cur = head.res[2];
		endcase
	end

	assign load    = !empty && (!out_valid_q || out_ready);
	assign is_last = (idx_q == head.cnt - 2'd1);
	assign pop     = load && is_last;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (load) idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status      <= cur.status;
			pixel_color <= cur.color;
			last        <= is_last;
			if (cur.status == ST_PIXEL) begin
				pixel_x <= $unsigned(origin_x) + cur.dx;
				pixel_y <= $unsigned(origin_y) + cur.dy;
			end else begin
				pixel_x <= '0;
				pixel_y <= '0;
			end
		end
	end

endmodule
